// ===== sv/phd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the packet header deframer.
// No dependencies; imported by every module of the block.
package phd_pkg;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned TYPE_W     = 16;
  localparam int unsigned ID_W       = 64;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // Header geometry: eight header bytes, message id ends at packet byte 16.
  localparam logic [LEN_W-1:0] HDR_BYTES  = LEN_W'(8);
  localparam logic [LEN_W-1:0] ID_END_POS = LEN_W'(16);
  localparam int unsigned      ID_FLAG_BIT = 1;

  // Header positions that select how a byte is used.
  localparam logic [POS_W-1:0] POS_MAGIC1    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_LAST  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_TYPE_LAST = POS_W'(6);
  localparam logic [POS_W-1:0] POS_FLAGS     = POS_W'(7);
  localparam logic [POS_W-1:0] POS_ID_END    = POS_W'(16);

  // Role of a word within its packet.
  typedef enum logic [2:0] {
    KIND_START,
    KIND_MAGIC,
    KIND_LEN,
    KIND_TYPE,
    KIND_FLAGS,
    KIND_ID,
    KIND_PAYLOAD
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_MAGIC  = 2'd1,
    STATUS_TOO_SHORT  = 2'd2,
    STATUS_ID_MISSING = 2'd3
  } status_t;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    kind_t      kind;
    logic       is_header;
    logic       pkt_end;
    status_t    status;
  } entry_t;

endpackage

// ===== sv/phd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts stream words, tracks packet position, length and magic.
// Depends on phd_pkg; feeds classified words into phd_fifo.
module phd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr,
  input  logic [7:0]      cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  output logic            push_valid,
  input  logic            push_ready,
  output phd_pkg::entry_t push_data
);
  import phd_pkg::*;

  logic [7:0]       magic_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             magic_ok_r, magic_ok_nxt;
  logic             accept;
  logic             byte_match;
  logic             pkt_end;
  kind_t            kind;
  status_t          status;

  assign accept     = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign byte_match = (in_data_byte == magic_r);

  // Classify the word by its position in the packet.
  always_comb begin
    priority if (pos_r == '0)                kind = KIND_START;
    else if (pos_r == POS_MAGIC1)            kind = KIND_MAGIC;
    else if (pos_r <= POS_LEN_LAST)          kind = KIND_LEN;
    else if (pos_r <= POS_TYPE_LAST)         kind = KIND_TYPE;
    else if (pos_r == POS_FLAGS)             kind = KIND_FLAGS;
    else if (pos_r < POS_ID_END)             kind = KIND_ID;
    else                                     kind = KIND_PAYLOAD;
  end

  // Header state updates and the end-of-packet decision.
  always_comb begin
    magic_ok_nxt = magic_ok_r;
    len_nxt      = len_r;
    pkt_end      = 1'b0;
    status       = STATUS_OK;
    unique case (kind)
      KIND_START: begin
        magic_ok_nxt = byte_match;
        len_nxt      = '0;
      end
      KIND_MAGIC: magic_ok_nxt = magic_ok_r && byte_match;
      KIND_LEN:   len_nxt = {len_r[LEN_W-9:0], in_data_byte};
      default:    ;
    endcase
    if (kind == KIND_FLAGS) begin
      if (!magic_ok_r) begin
        pkt_end = 1'b1;
        status  = STATUS_BAD_MAGIC;
      end else if (len_r < HDR_BYTES) begin
        pkt_end = 1'b1;
        status  = STATUS_TOO_SHORT;
      end else if (len_r == HDR_BYTES) begin
        pkt_end = 1'b1;
      end
    end else if (kind == KIND_ID || kind == KIND_PAYLOAD) begin
      pkt_end = (({1'b0, pos_r} + (POS_W + 1)'(1)) >= {1'b0, len_r});
    end
    pos_nxt = pkt_end ? '0 : pos_r + POS_W'(1);
  end

  assign push_data.data_byte = in_data_byte;
  assign push_data.kind      = kind;
  assign push_data.is_header = (pos_r < HDR_BYTES);
  assign push_data.pkt_end   = pkt_end;
  assign push_data.status    = status;

  // Position, length and magic state advance on each accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= '0;
      pos_r      <= '0;
      len_r      <= '0;
      magic_ok_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        magic_r <= cfg_data;
      end
      if (accept) begin
        pos_r      <= pos_nxt;
        len_r      <= len_nxt;
        magic_ok_r <= magic_ok_nxt;
      end
    end
  end

endmodule

// ===== sv/phd_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified words between the front and the back.
// Depends on phd_pkg for the entry type and depth.
module phd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  phd_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output phd_pkg::entry_t pop_data
);
  import phd_pkg::*;

  entry_t           mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             push, pop;

  assign push_ready = (count_r != (PTR_W + 1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + (PTR_W + 1)'(1);
      else if (pop && !push) count_r <= count_r - (PTR_W + 1)'(1);
    end
  end

endmodule

// ===== sv/phd_back.sv =====
`timescale 1ns / 1ps
// Back end: gathers length, type, flags and id, settles the status, holds the result.
// Depends on phd_pkg; takes classified words from phd_fifo.
module phd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  phd_pkg::entry_t           pop_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte_out,
  output logic                      out_is_header,
  output logic                      out_packet_end,
  output logic [1:0]                out_status,
  output logic [phd_pkg::LEN_W-1:0]  out_packet_length,
  output logic [phd_pkg::TYPE_W-1:0] out_packet_type,
  output logic                      out_id_present,
  output logic [phd_pkg::ID_W-1:0]   out_msg_id
);
  import phd_pkg::*;

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;
  logic              flag_r, flag_nxt;
  logic [ID_W-1:0]   shift_r, shift_nxt;
  status_t           status_res;
  logic [ID_W-1:0]   id_res;
  logic              take;

  logic              out_valid_r;
  logic [7:0]        byte_r;
  logic              hdr_r, end_r, flag_out_r;
  status_t           status_r;
  logic [LEN_W-1:0]  len_out_r;
  logic [TYPE_W-1:0] type_out_r;
  logic [ID_W-1:0]   id_out_r;

  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;

  // Header field gathering for the word being taken.
  always_comb begin
    len_nxt   = len_r;
    type_nxt  = type_r;
    flag_nxt  = flag_r;
    shift_nxt = shift_r;
    unique case (pop_data.kind)
      KIND_START: begin
        len_nxt   = '0;
        type_nxt  = '0;
        flag_nxt  = 1'b0;
        shift_nxt = '0;
      end
      KIND_LEN:   len_nxt = {len_r[LEN_W-9:0], pop_data.data_byte};
      KIND_TYPE:  type_nxt = {type_r[TYPE_W-9:0], pop_data.data_byte};
      KIND_FLAGS: flag_nxt = pop_data.data_byte[ID_FLAG_BIT];
      KIND_ID:    shift_nxt = {shift_r[ID_W-9:0], pop_data.data_byte};
      default:    ;
    endcase
  end

  // Final status and id: the id is given only when all eight id bytes came.
  always_comb begin
    status_res = pop_data.status;
    id_res     = '0;
    if (pop_data.pkt_end && pop_data.status == STATUS_OK && flag_nxt) begin
      if (len_nxt < ID_END_POS) begin
        status_res = STATUS_ID_MISSING;
      end else begin
        id_res = shift_nxt;
      end
    end
  end

  // Gathered header state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      type_r  <= '0;
      flag_r  <= 1'b0;
      shift_r <= '0;
    end else if (take) begin
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      flag_r  <= flag_nxt;
      shift_r <= shift_nxt;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  // Output payload; decoded fields read zero except at packet end.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r     <= pop_data.data_byte;
      hdr_r      <= pop_data.is_header;
      end_r      <= pop_data.pkt_end;
      status_r   <= pop_data.pkt_end ? status_res : STATUS_OK;
      len_out_r  <= pop_data.pkt_end ? len_nxt : '0;
      type_out_r <= pop_data.pkt_end ? type_nxt : '0;
      flag_out_r <= pop_data.pkt_end && flag_nxt;
      id_out_r   <= pop_data.pkt_end ? id_res : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_out      = byte_r;
  assign out_is_header     = hdr_r;
  assign out_packet_end    = end_r;
  assign out_status        = status_r;
  assign out_packet_length = len_out_r;
  assign out_packet_type   = type_out_r;
  assign out_id_present    = flag_out_r;
  assign out_msg_id        = id_out_r;

endmodule

// ===== sv/packet_header_deframer_top.sv =====
`timescale 1ns / 1ps
// Packet header deframer. Flow: an accepted word is written into the queue and
// moves from there into the output register once that register is free, where its
// result is offered. Throughput: one word per cycle, sustained while the
// result side keeps taking; a two-entry queue and the output register let each
// side stall on its own. Reset clears the packet position, gathered header state,
// queue, output valid and the magic register. Depends on phd_pkg, phd_front/fifo/back.
module packet_header_deframer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_magic_value,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte_out,
  output logic                      out_is_header,
  output logic                      out_packet_end,
  output logic [1:0]                out_status,
  output logic [phd_pkg::LEN_W-1:0]  out_packet_length,
  output logic [phd_pkg::TYPE_W-1:0] out_packet_type,
  output logic                      out_id_present,
  output logic [phd_pkg::ID_W-1:0]   out_msg_id
);
  import phd_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data;

  // The magic register is always writable.
  assign cfg_ready = 1'b1;

  phd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_magic_value),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  phd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  phd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_data          (pop_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_out      (out_byte_out),
    .out_is_header     (out_is_header),
    .out_packet_end    (out_packet_end),
    .out_status        (out_status),
    .out_packet_length (out_packet_length),
    .out_packet_type   (out_packet_type),
    .out_id_present    (out_id_present),
    .out_msg_id        (out_msg_id)
  );

  // Decoded fields stay zero on words that do not end a packet.
  a_fields_zero_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_end |->
      out_status == STATUS_OK && out_packet_length == '0 && out_msg_id == '0)
    else $error("decoded fields set on a word that does not end a packet");

  // A message id is only reported for a good packet that announced one.
  a_id_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_id != '0 |->
      out_packet_end && out_id_present && out_status == STATUS_OK)
    else $error("message id reported without a good id-bearing packet");

  // A too-short packet ends inside the header with a length below eight.
  a_short_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_TOO_SHORT |->
      out_is_header && out_packet_length < HDR_BYTES)
    else $error("too-short status outside the header or with a legal length");

  // Reset empties the result register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still valid after reset");

endmodule

// ===== dv/packet_header_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for packet_header_deframer_top: drives byte streams of
// well-formed and broken packets under random stalls and checks every result word.
// Depends on phd_pkg and the packet_header_deframer_top RTL.
module packet_header_deframer_top_tb;
  import phd_pkg::*;

  // One expected result word.
  typedef struct packed {
    logic [7:0]        data_byte;
    logic              is_header;
    logic              last;
    status_t           status;
    logic [LEN_W-1:0]  length;
    logic [TYPE_W-1:0] ptype;
    logic              id_flag;
    logic [ID_W-1:0]   id;
  } deframe_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_magic_value = 8'h00;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte_out;
  logic out_is_header;
  logic out_packet_end;
  logic [1:0] out_status;
  logic [LEN_W-1:0] out_packet_length;
  logic [TYPE_W-1:0] out_packet_type;
  logic out_id_present;
  logic [ID_W-1:0] out_msg_id;

  // Stimulus and expectation stores.
  logic [7:0] tx_bytes_q[$];
  logic [7:0] magic_writes_q[$];
  deframe_word_t expected_words_q[$];

  int send_idle_pct = 32;
  int recv_idle_pct = 59;
  int hold_left = 0;
  int mismatch_count = 0;

  // Magic value the generator builds packets for.
  logic [7:0] gen_magic = 8'h00;

  // Predictor state: register copy and the packet being parsed.
  logic [7:0]        magic_copy = 8'h00;
  logic [POS_W-1:0]  cur_pos = '0;
  logic [LEN_W-1:0]  hdr_length = '0;
  logic [TYPE_W-1:0] hdr_type = '0;
  logic              magic_seen_ok = 1'b0;
  logic              id_wanted = 1'b0;
  logic [ID_W-1:0]   id_gathered = '0;

  packet_header_deframer_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_magic_value   (cfg_magic_value),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_out      (out_byte_out),
    .out_is_header     (out_is_header),
    .out_packet_end    (out_packet_end),
    .out_status        (out_status),
    .out_packet_length (out_packet_length),
    .out_packet_type   (out_packet_type),
    .out_id_present    (out_id_present),
    .out_msg_id        (out_msg_id)
  );

  always #5 clk = ~clk;

  // Parse one byte and return the result word it should produce.
  function automatic deframe_word_t deframe_byte(logic [7:0] b);
    deframe_word_t w;
    logic [POS_W-1:0] pos;
    logic done;
    status_t st;
    w = '0;
    pos = cur_pos;
    done = 1'b0;
    st = STATUS_OK;
    if (pos == '0) begin
      magic_seen_ok = (b == magic_copy);
      hdr_length = '0;
      hdr_type = '0;
      id_wanted = 1'b0;
      id_gathered = '0;
    end else if (pos == POS_MAGIC1) begin
      magic_seen_ok = magic_seen_ok && (b == magic_copy);
    end else if (pos <= POS_LEN_LAST) begin
      hdr_length = {hdr_length[LEN_W-9:0], b};
    end else if (pos <= POS_TYPE_LAST) begin
      hdr_type = {hdr_type[TYPE_W-9:0], b};
    end else if (pos == POS_FLAGS) begin
      id_wanted = b[ID_FLAG_BIT];
    end else if (pos < POS_ID_END) begin
      id_gathered = {id_gathered[ID_W-9:0], b};
    end

    // The flags byte closes aborted or header-only packets.
    if (pos == POS_FLAGS) begin
      if (!magic_seen_ok) begin
        done = 1'b1;
        st = STATUS_BAD_MAGIC;
      end else if (hdr_length < HDR_BYTES) begin
        done = 1'b1;
        st = STATUS_TOO_SHORT;
      end else if (hdr_length == HDR_BYTES) begin
        done = 1'b1;
      end
    end else if (pos >= HDR_BYTES) begin
      done = ({1'b0, pos} + 25'd1) >= {1'b0, hdr_length};
    end

    w.data_byte = b;
    w.is_header = (pos < HDR_BYTES);
    w.last = done;
    if (done) begin
      if (st == STATUS_OK && id_wanted) begin
        if (hdr_length < ID_END_POS) st = STATUS_ID_MISSING;
        else w.id = id_gathered;
      end
      w.status = st;
      w.length = hdr_length;
      w.ptype = hdr_type;
      w.id_flag = id_wanted;
      cur_pos = '0;
    end else begin
      cur_pos = pos + 1'b1;
    end
    return w;
  endfunction

  // Driver for the configuration and byte channels; predicts each accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      in_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) magic_copy = cfg_magic_value;
      if (in_valid && in_ready) expected_words_q.push_back(deframe_byte(in_data_byte));
      if (!cfg_valid || cfg_ready) begin
        if (magic_writes_q.size() != 0) begin
          cfg_valid <= 1'b1;
          cfg_magic_value <= magic_writes_q.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
      if (!in_valid || in_ready) begin
        if (tx_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data_byte <= tx_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off counted down here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    deframe_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words_q.size() == 0) begin
        flag_mismatch("result word arrived with nothing expected");
      end else begin
        want = expected_words_q.pop_front();
        check_field("byte_out", 64'(out_byte_out), 64'(want.data_byte));
        check_field("is_header", 64'(out_is_header), 64'(want.is_header));
        check_field("packet_end", 64'(out_packet_end), 64'(want.last));
        check_field("status", 64'(out_status), 64'(want.status));
        check_field("packet_length", 64'(out_packet_length), 64'(want.length));
        check_field("packet_type", 64'(out_packet_type), 64'(want.ptype));
        check_field("id_present", 64'(out_id_present), 64'(want.id_flag));
        check_field("msg_id", out_msg_id, want.id);
      end
    end
  end

  // Wait until every queued byte went in and every result came out.
  task automatic wait_drained();
    while (tx_bytes_q.size() != 0 || in_valid || expected_words_q.size() != 0)
      @(negedge clk);
  endtask

  // Write the magic register; only called with the block idle.
  task automatic write_magic(logic [7:0] value);
    magic_writes_q.push_back(value);
    gen_magic = value;
    @(negedge clk);
    while (magic_writes_q.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  // Queue a header and, when the packet will be accepted, its payload.
  task automatic queue_packet(logic [7:0] m0, logic [7:0] m1, logic [LEN_W-1:0] len,
                              logic [TYPE_W-1:0] ptype, logic [7:0] flags);
    tx_bytes_q.push_back(m0);
    tx_bytes_q.push_back(m1);
    tx_bytes_q.push_back(len[23:16]);
    tx_bytes_q.push_back(len[15:8]);
    tx_bytes_q.push_back(len[7:0]);
    tx_bytes_q.push_back(ptype[15:8]);
    tx_bytes_q.push_back(ptype[7:0]);
    tx_bytes_q.push_back(flags);
    if (m0 == gen_magic && m1 == gen_magic && len > HDR_BYTES)
      for (int i = int'(HDR_BYTES); i < int'(len); i++) tx_bytes_q.push_back(8'($urandom));
  endtask

  // Mostly well-formed packets with random content, the rest broken headers.
  task automatic queue_random_packet();
    int pick;
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] flags;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(0, 99);
    m0 = gen_magic;
    m1 = gen_magic;
    flags = 8'($urandom);
    if (pick < 65) begin
      len = (pick < 4) ? 24'($urandom_range(40, 200)) : 24'($urandom_range(8, 28));
    end else if (pick < 75) begin
      len = 24'($urandom_range(0, 7));
    end else if (pick < 85) begin
      len = 24'($urandom);
      case ($urandom_range(0, 2))
        0: m0 = gen_magic ^ 8'($urandom_range(1, 255));
        1: m1 = gen_magic ^ 8'($urandom_range(1, 255));
        default: begin
          m0 = gen_magic ^ 8'($urandom_range(1, 255));
          m1 = gen_magic ^ 8'($urandom_range(1, 255));
        end
      endcase
    end else if (pick < 95) begin
      len = (pick < 90) ? HDR_BYTES : ID_END_POS;
      flags[ID_FLAG_BIT] = 1'b1;
    end else begin
      // Noise: random header bytes that never match the magic.
      m0 = gen_magic ^ 8'($urandom_range(1, 255));
      m1 = 8'($urandom);
      len = 24'($urandom);
    end
    queue_packet(m0, m1, len, 16'($urandom), flags);
  endtask

  task automatic run_random_phase(int n_bytes);
    while (tx_bytes_q.size() < n_bytes) queue_random_packet();
    wait_drained();
  endtask

  // Limit on the whole run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cases with the magic value left at its reset value.
    queue_packet(8'h00, 8'h00, HDR_BYTES, 16'hFFFF, 8'hFF);
    queue_packet(8'hFF, 8'h00, 24'd3, 16'h0000, 8'h00);
    queue_packet(8'h00, 8'h00, 24'd0, 16'h0000, 8'h00);
    wait_drained();
    write_magic(8'hFF);
    queue_packet(8'hFF, 8'hFF, ID_END_POS, 16'h8001, 8'h02);
    wait_drained();

    // The register changes between the two magic bytes of one packet.
    tx_bytes_q.push_back(8'hFF);
    wait_drained();
    write_magic(8'h00);
    tx_bytes_q.push_back(8'h00);
    tx_bytes_q.push_back(8'h00);
    tx_bytes_q.push_back(8'h00);
    tx_bytes_q.push_back(8'h08);
    tx_bytes_q.push_back(8'h12);
    tx_bytes_q.push_back(8'h34);
    tx_bytes_q.push_back(8'h00);
    wait_drained();

    // Random traffic under three stall patterns.
    write_magic(8'($urandom));
    run_random_phase(100);
    send_idle_pct = 59;
    recv_idle_pct = 32;
    write_magic(8'hFF);
    run_random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_magic(8'($urandom));
    run_random_phase(100);

    // Long result-side hold while bytes keep coming, so the input stalls.
    hold_left = 300;
    run_random_phase(50);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
